### rtl/gdnr_pkg.sv
// shared types and constants for the grid domain neighbour rank block
`default_nettype none

package gdnr_pkg;

  localparam int AXES       = 3;
  localparam int RANK_W     = 12;
  localparam int CELL_W     = 16;
  localparam int NB_W       = 13;
  localparam int NB_COUNT   = 26;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W = ((RANK_W + 7) / 8) * 8;

  localparam int OUT_FIELDS_W = AXES * RANK_W + 2 * AXES * CELL_W + NB_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_NDIM       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LOG2_PROCS = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_EXTENT_X   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_EXTENT_Y   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_EXTENT_Z   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_CELLS_X    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_CELLS_Y    = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_CELLS_Z    = 3'd7;

  // neighbour directions in emission order, one bit per neighbour slot
  localparam logic [NB_COUNT-1:0] NB_X_NEG = 26'h1454541;
  localparam logic [NB_COUNT-1:0] NB_X_POS = 26'h28A8A82;
  localparam logic [NB_COUNT-1:0] NB_Y_NEG = 26'h0D0D0C4;
  localparam logic [NB_COUNT-1:0] NB_Y_POS = 26'h3232308;
  localparam logic [NB_COUNT-1:0] NB_Z_NEG = 26'h003FC10;
  localparam logic [NB_COUNT-1:0] NB_Z_POS = 26'h3FC0020;

  localparam logic [NB_W-1:0] NB_NONE = {NB_W{1'b1}};

  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [NB_W-1:0]      neighbour_rank;
    logic [CELL_W-1:0]    offset_z;
    logic [CELL_W-1:0]    offset_y;
    logic [CELL_W-1:0]    offset_x;
    logic [CELL_W-1:0]    sub_cells_z;
    logic [CELL_W-1:0]    sub_cells_y;
    logic [CELL_W-1:0]    sub_cells_x;
    logic [RANK_W-1:0]    coord_z;
    logic [RANK_W-1:0]    coord_y;
    logic [RANK_W-1:0]    coord_x;
  } out_word_t;

endpackage

`default_nettype wire

### rtl/grid_domain_neighbour_ranks_top.sv
// recursive bisection domain decomposition with neighbour rank listing
//
// in_* carries one rank per word. out_* returns one word per abutting
// subdomain, in fixed order (faces, xy edges, zn plane, zp plane), each word
// repeating the subdomain coordinates, local cell counts and offsets; tlast
// marks the final word of a rank. A rank without neighbours gives a single
// word with neighbour_rank -1. cfg_* writes the registers.
// out_tvalid rises after the decode, neighbour, serializer and output
// registers. The serializer stage emits one word per cycle unless out_tready
// stalls it: one per neighbour (up to 26), or one word if there are none;
// while it drains, the next ranks move through the decode and neighbour
// stages behind it. After reset and after each cfg write, the split
// sequencer runs one step per cycle with in_tready low: min(log2_procs,
// MAX_LOG2_PROCS) bisections and a last step. A stall on out_tready holds
// the output register and backs up the stages; nothing is lost.
`default_nettype none

module grid_domain_neighbour_ranks_top #(
  parameter int MAX_LOG2_PROCS = 12,
  parameter int MAX_DIMS       = 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wen,
  input  wire logic [gdnr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [gdnr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // rank
  input  wire logic [gdnr_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // coord_x, coord_y, coord_z, sub_cells_x/y/z, offset_x/y/z, neighbour_rank
  output logic [gdnr_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                   out_tlast
);
  import gdnr_pkg::*;

  localparam int KW = $clog2(MAX_LOG2_PROCS + 1);
  localparam int VW = CELL_W + MAX_LOG2_PROCS;

  // configuration registers
  logic [1:0]        ndim_r;
  logic [3:0]        lp_r;
  logic [CELL_W-1:0] ext_r   [AXES];
  logic [CELL_W-1:0] cells_r [AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ndim_r <= 2'd3;
      lp_r   <= '0;
      for (int a = 0; a < AXES; a++) begin
        ext_r[a]   <= CELL_W'(1);
        cells_r[a] <= CELL_W'(1);
      end
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_NDIM:       ndim_r     <= cfg_wdata[1:0];
        REG_LOG2_PROCS: lp_r       <= cfg_wdata[3:0];
        REG_EXTENT_X:   ext_r[0]   <= cfg_wdata;
        REG_EXTENT_Y:   ext_r[1]   <= cfg_wdata;
        REG_EXTENT_Z:   ext_r[2]   <= cfg_wdata;
        REG_CELLS_X:    cells_r[0] <= cfg_wdata;
        REG_CELLS_Y:    cells_r[1] <= cfg_wdata;
        REG_CELLS_Z:    cells_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [1:0]    nd_eff;
  logic [KW-1:0] lp_eff;

  always_comb begin
    if (ndim_r == 2'd0) nd_eff = 2'd1;
    else if (32'(ndim_r) > MAX_DIMS) nd_eff = 2'(MAX_DIMS);
    else nd_eff = ndim_r;
    if (32'(lp_r) > MAX_LOG2_PROCS) lp_eff = KW'(MAX_LOG2_PROCS);
    else lp_eff = KW'(lp_r);
  end

  // split sequencer: one bisection per cycle
  logic          busy_r;
  logic [KW-1:0] step_r;
  logic [1:0]    maxdir_r;
  logic [KW-1:0] k_r [AXES];
  logic [1:0]    best_dir;

  always_comb begin
    logic [VW-1:0] best_v;
    logic [VW-1:0] cand_v;
    best_v   = '0;
    best_dir = maxdir_r;
    for (int a = 0; a < AXES; a++) begin
      cand_v = VW'(ext_r[a]) << (KW'(MAX_LOG2_PROCS) - k_r[a]);
      if (a < int'(nd_eff) && cand_v > best_v) begin
        best_v   = cand_v;
        best_dir = 2'(a);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wen) begin
      busy_r   <= 1'b1;
      step_r   <= '0;
      maxdir_r <= '0;
      for (int a = 0; a < AXES; a++) k_r[a] <= '0;
    end else if (busy_r) begin
      if (step_r < lp_eff) begin
        k_r[best_dir] <= k_r[best_dir] + KW'(1);
        maxdir_r      <= best_dir;
        step_r        <= step_r + KW'(1);
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

  // per configuration values
  logic [KW:0]       ksum;
  logic [CELL_W-1:0] sub_r [AXES];
  logic [NB_W-1:0]   stride_y_r;
  logic [NB_W-1:0]   stride_z_r;

  assign ksum = {1'b0, k_r[0]} + {1'b0, k_r[1]};

  always_ff @(posedge clk) begin
    for (int a = 0; a < AXES; a++) begin
      sub_r[a] <= (a < int'(nd_eff)) ? (cells_r[a] >> k_r[a]) : '0;
    end
    stride_y_r <= NB_W'(1) << k_r[0];
    stride_z_r <= NB_W'(1) << ksum;
  end

  // handshake chain
  logic s1_v_r, s2_v_r, em_v_r, out_v_r;
  logic out_free, em_fire, em_last, em_ready, s2_ready, s1_ready, in_fire;

  assign out_free  = !out_v_r || out_tready;
  assign em_fire   = em_v_r && out_free;
  assign em_ready  = !em_v_r || (em_fire && em_last);
  assign s2_ready  = !s2_v_r || em_ready;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_tready = !busy_r && !cfg_wen && s1_ready;
  assign in_fire   = in_tvalid && in_tready;

  // stage 1: rank to coordinates
  logic [RANK_W-1:0] in_rank;
  logic [RANK_W-1:0] ix_nxt [AXES];
  logic [RANK_W-1:0] s1_rank_r;
  logic [RANK_W-1:0] s1_ix_r [AXES];

  always_comb begin
    in_rank   = in_tdata[RANK_W-1:0] & ~({RANK_W{1'b1}} << lp_eff);
    ix_nxt[0] = in_rank & ~({RANK_W{1'b1}} << k_r[0]);
    ix_nxt[1] = (in_rank >> k_r[0]) & ~({RANK_W{1'b1}} << k_r[1]);
    ix_nxt[2] = in_rank >> ksum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (s1_ready) s1_v_r <= in_fire;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_rank_r <= in_rank;
      s1_ix_r   <= ix_nxt;
    end
  end

  // stage 2: offsets and neighbour candidates
  logic [AXES-1:0]     dneg, dpos;
  logic [CELL_W-1:0]   off_nxt [AXES];
  logic [NB_COUNT-1:0] mask_nxt;
  logic [NB_W-1:0]     nb_nxt [NB_COUNT];

  always_comb begin
    logic [NB_W-1:0] tx, ty, tz;
    for (int a = 0; a < AXES; a++) begin
      dneg[a]    = s1_ix_r[a] != '0;
      dpos[a]    = (32'(k_r[a]) > RANK_W) ||
                   (s1_ix_r[a] != ~({RANK_W{1'b1}} << k_r[a]));
      off_nxt[a] = CELL_W'({{(CELL_W-RANK_W){1'b0}}, s1_ix_r[a]} * sub_r[a]);
    end
    for (int i = 0; i < NB_COUNT; i++) begin
      mask_nxt[i] = !(NB_X_NEG[i] && !dneg[0]) && !(NB_X_POS[i] && !dpos[0]) &&
                    !(NB_Y_NEG[i] && !dneg[1]) && !(NB_Y_POS[i] && !dpos[1]) &&
                    !(NB_Z_NEG[i] && !dneg[2]) && !(NB_Z_POS[i] && !dpos[2]);
      tx = NB_X_POS[i] ? NB_W'(1) : (NB_X_NEG[i] ? {NB_W{1'b1}} : '0);
      ty = NB_Y_POS[i] ? stride_y_r : (NB_Y_NEG[i] ? (~stride_y_r + NB_W'(1)) : '0);
      tz = NB_Z_POS[i] ? stride_z_r : (NB_Z_NEG[i] ? (~stride_z_r + NB_W'(1)) : '0);
      nb_nxt[i] = {1'b0, s1_rank_r} + tx + ty + tz;
    end
  end

  logic [RANK_W-1:0]   s2_ix_r   [AXES];
  logic [CELL_W-1:0]   s2_off_r  [AXES];
  logic [NB_COUNT-1:0] s2_mask_r;
  logic [NB_W-1:0]     s2_nb_r   [NB_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (s2_ready) s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_v_r) begin
      s2_ix_r   <= s1_ix_r;
      s2_off_r  <= off_nxt;
      s2_mask_r <= mask_nxt;
      s2_nb_r   <= nb_nxt;
    end
  end

  // stage 3: serializer, one neighbour per word
  logic [RANK_W-1:0]   em_ix_r   [AXES];
  logic [CELL_W-1:0]   em_off_r  [AXES];
  logic [NB_COUNT-1:0] em_mask_r;
  logic [NB_W-1:0]     em_nb_r   [NB_COUNT];
  logic [NB_COUNT-1:0] em_rest, em_low;
  logic [NB_W-1:0]     em_sel;

  always_comb begin
    em_rest = em_mask_r & (em_mask_r - NB_COUNT'(1));
    em_low  = em_mask_r & ~em_rest;
    em_last = em_rest == '0;
    em_sel  = (em_mask_r == '0) ? NB_NONE : '0;
    for (int i = 0; i < NB_COUNT; i++) begin
      if (em_low[i]) em_sel = em_sel | em_nb_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) em_v_r <= 1'b0;
    else if (em_ready) em_v_r <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (em_ready && s2_v_r) begin
      em_ix_r   <= s2_ix_r;
      em_off_r  <= s2_off_r;
      em_mask_r <= s2_mask_r;
      em_nb_r   <= s2_nb_r;
    end else if (em_fire) begin
      em_mask_r <= em_rest;
    end
  end

  // output register
  out_word_t word_nxt;
  out_word_t out_word_r;
  logic      out_last_r;

  always_comb begin
    word_nxt.pad            = '0;
    word_nxt.neighbour_rank = em_sel;
    word_nxt.offset_z       = em_off_r[2];
    word_nxt.offset_y       = em_off_r[1];
    word_nxt.offset_x       = em_off_r[0];
    word_nxt.sub_cells_z    = sub_r[2];
    word_nxt.sub_cells_y    = sub_r[1];
    word_nxt.sub_cells_x    = sub_r[0];
    word_nxt.coord_z        = em_ix_r[2];
    word_nxt.coord_y        = em_ix_r[1];
    word_nxt.coord_x        = em_ix_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (out_free) out_v_r <= em_v_r;
  end

  always_ff @(posedge clk) begin
    if (em_fire) begin
      out_word_r <= word_nxt;
      out_last_r <= em_last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_word_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
